// ===== hdl/lss_pkg.sv =====
// shared types, codes and sizes for the lifo stack with search
`timescale 1ns / 1ps

package lss_pkg;

   localparam int LSS_DEPTH  = 64;
   localparam int LSS_WORD_W = 32;

   typedef enum logic [2:0] {
      REQ_PUSH   = 3'd0,
      REQ_POP    = 3'd1,
      REQ_PEEK   = 3'd2,
      REQ_SEARCH = 3'd3,
      REQ_DUMP   = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_code_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [2:0]                   req_type;
      logic signed [LSS_WORD_W-1:0] value_in;
   } lss_req_type;

   typedef struct packed {
      logic [1:0]                   status;
      logic signed [LSS_WORD_W-1:0] value_out;
      logic                         last;
   } lss_rsp_type;

endpackage

// ===== hdl/lss_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module lss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== hdl/lifo_stack_with_search_unit.sv =====
// top level of the lifo stack with push, pop, peek, search and dump
//
//   port group   direction   moves
//   req_*        in          one request per transfer: req_type, value_in
//   rsp_*        out         one result per transfer: status, value_out, last
//
// push goes straight to emit; on a non-empty stack pop and peek take one evaluate
// step, search one per entry compared, dump an evaluate and emit step per entry;
// the single ram read port and shared word comparator serve one entry per step.
// reset is synchronous and clears the entry count, the sequencer and rsp_valid;
// the ram is not cleared and only entries below the count are read.
// a stalled result holds in the output register; the sequencer waits in its
// emit step until the register is free.
`timescale 1ns / 1ps

module lifo_stack_with_search_unit #(
   parameter int DEPTH = lss_pkg::LSS_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lss_pkg::lss_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lss_pkg::lss_rsp_type rsp_data
);

   import lss_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type               state_ff, state_in;
   logic [2:0]              op_ff, op_in;
   logic [LSS_WORD_W-1:0]   key_ff, key_in;
   logic [AW-1:0]           ptr_ff, ptr_in;
   logic [CW-1:0]           count_ff, count_in;
   lss_rsp_type             pend_ff, pend_in;
   lss_rsp_type             rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    wr_en, rd_en;
   logic [AW-1:0]           wr_addr, rd_addr;
   logic [LSS_WORD_W-1:0]   wr_data, rd_data;

   logic                    req_fire, slot_free, is_full, is_empty, hit;
   logic [CW-1:0]           count_dec;
   logic [AW-1:0]           top_addr, ptr_dec;

   lss_ram #(
      .WIDTH (LSS_WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign count_dec = count_ff - CW'(1);
   assign top_addr  = count_dec[AW-1:0];
   assign ptr_dec   = ptr_ff - AW'(1);
   // shared comparator: one stored word against the search key per step
   assign hit       = (rd_data == key_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_data.req_type) inside
                  REQ_PUSH: state_in = S_EMIT;
                  REQ_POP, REQ_PEEK, REQ_SEARCH, REQ_DUMP:
                     state_in = is_empty ? S_EMIT : S_EVAL;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_EVAL: begin
            if (op_ff == REQ_SEARCH && !hit && ptr_ff != '0) begin
               state_in = S_EVAL;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               state_in = (op_ff == REQ_DUMP && !pend_ff.last) ? S_EVAL : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = req_data.value_in;
      rd_en        = 1'b0;
      rd_addr      = top_addr;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in   = req_data.req_type;
               key_in  = req_data.value_in;
               ptr_in  = top_addr;
               pend_in = '{status: ST_OK, value_out: '0, last: 1'b1};
               unique case (req_data.req_type) inside
                  REQ_PUSH: begin
                     if (is_full) begin
                        pend_in.status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  REQ_POP, REQ_PEEK, REQ_SEARCH, REQ_DUMP: begin
                     if (is_empty) begin
                        pend_in.status = ST_EMPTY;
                     end else begin
                        rd_en = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_EVAL: begin
            unique case (op_ff) inside
               REQ_POP: begin
                  pend_in.value_out = rd_data;
                  count_in          = count_dec;
               end
               REQ_PEEK: pend_in.value_out = rd_data;
               REQ_SEARCH: begin
                  if (hit) begin
                     pend_in.status = ST_OK;
                  end else if (ptr_ff == '0) begin
                     pend_in.status = ST_NOTFOUND;
                  end else begin
                     ptr_in  = ptr_dec;
                     rd_en   = 1'b1;
                     rd_addr = ptr_dec;
                  end
               end
               REQ_DUMP: begin
                  pend_in.value_out = rd_data;
                  pend_in.last      = (ptr_ff == '0);
               end
               default: ;
            endcase
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               // dump walks on to the next entry down
               if (op_ff == REQ_DUMP && !pend_ff.last) begin
                  ptr_in  = ptr_dec;
                  rd_en   = 1'b1;
                  rd_addr = ptr_dec;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      key_ff  <= key_in;
      ptr_ff  <= ptr_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/lss_checker.sv =====
// port-level checks for the lifo stack top level, bound in below
`timescale 1ns / 1ps

module lss_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input lss_pkg::lss_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input lss_pkg::lss_rsp_type rsp_data
);

   import lss_pkg::*;

   // a held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // reset empties the output register
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid just after reset");

   // an accepted push keeps the sequencer busy for its result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.req_type == REQ_PUSH |=> req_stall)
      else $error("push transfer did not occupy the sequencer");

   // an unused request code leaves the block ready
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_data.req_type == 3'd5 || req_data.req_type == 3'd6 ||
       req_data.req_type == 3'd7) |=> !req_stall)
      else $error("unused request code started work");

endmodule

bind lifo_stack_with_search_unit lss_checker u_lss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== dv/tb_top.sv =====
// self-checking testbench for the lifo stack with search, with a directed table and random traffic
`timescale 1ns / 1ps

module tb_top;
   import lss_pkg::*;

   localparam int RANDOM_ITEMS   = 370;
   localparam int HOLD_CYCLES    = 250;
   localparam int DRAIN_CYCLES   = 200;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} traffic_mix_type;

   typedef struct {
      lss_req_type req;
      bit          typed;
      lss_rsp_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   lss_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   lss_rsp_type rsp_data;

   // stack contents as the testbench sees them
   logic signed [LSS_WORD_W-1:0] shadow_words [LSS_DEPTH];
   int                           shadow_count;
   int                           peak_depth;
   lss_rsp_type                  pending_results_q [$];

   stim_row_type directed_rows [$];
   bit           cur_typed;
   lss_rsp_type  cur_want;
   bit           calm;
   int           hold_asks;
   int           holds_served;
   int           mismatches;
   int           requests_done;
   int           results_done;
   int           status_seen [4];
   int           quiet_cycles;

   logic [31:0] key_pool [8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                                 32'h0000_0001, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 32'h0000_ffff};

   lifo_stack_with_search_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // works out the results of one request and updates the shadow stack
   function automatic void predict_stack_op(input lss_req_type r);
      lss_rsp_type res;
      bit          hit;
      res = '0;
      res.last = 1'b1;
      hit = 1'b0;
      case (r.req_type)
         REQ_PUSH: begin
            if (shadow_count >= LSS_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               shadow_words[shadow_count] = r.value_in;
               shadow_count++;
               res.status = ST_OK;
            end
            pending_results_q.push_back(res);
         end
         REQ_POP, REQ_PEEK: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.status = ST_OK;
               res.value_out = shadow_words[shadow_count-1];
               if (r.req_type == REQ_POP) shadow_count--;
            end
            pending_results_q.push_back(res);
         end
         REQ_SEARCH: begin
            for (int i = 0; i < shadow_count; i++)
               if (shadow_words[i] == r.value_in) hit = 1'b1;
            if (shadow_count == 0) res.status = ST_EMPTY;
            else if (hit) res.status = ST_OK;
            else res.status = ST_NOTFOUND;
            pending_results_q.push_back(res);
         end
         REQ_DUMP: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
               pending_results_q.push_back(res);
            end else begin
               for (int i = 0; i < shadow_count; i++) begin
                  res.status = ST_OK;
                  res.value_out = shadow_words[shadow_count-1-i];
                  res.last = (i == shadow_count - 1);
                  pending_results_q.push_back(res);
               end
            end
         end
         default: ;  // unused codes leave everything alone
      endcase
      if (shadow_count > peak_depth) peak_depth = shadow_count;
   endfunction

   function automatic lss_req_type pick_request(input traffic_mix_type mix);
      lss_req_type r;
      int          roll;
      int          c_push;
      int          c_pop;
      int          c_peek;
      int          c_search;
      case (mix)
         MIX_FILL: begin
            c_push = 80; c_pop = 85; c_peek = 90; c_search = 95;
         end
         MIX_BALANCED: begin
            c_push = 35; c_pop = 60; c_peek = 75; c_search = 90;
         end
         default: begin
            c_push = 15; c_pop = 65; c_peek = 77; c_search = 90;
         end
      endcase
      roll = $urandom_range(99);
      r.value_in = $urandom;
      if (roll < c_push) begin
         r.req_type = REQ_PUSH;
         if ($urandom_range(1)) r.value_in = key_pool[$urandom_range(7)];
      end else if (roll < c_pop) begin
         r.req_type = REQ_POP;
      end else if (roll < c_peek) begin
         r.req_type = REQ_PEEK;
      end else if (roll < c_search) begin
         r.req_type = REQ_SEARCH;
         if ($urandom_range(99) < 60) r.value_in = key_pool[$urandom_range(7)];
      end else begin
         r.req_type = REQ_DUMP;
      end
      return r;
   endfunction

   function automatic void add_row(input logic [2:0] code, input logic [31:0] word,
                                   input bit typed, input logic [1:0] st,
                                   input logic [31:0] vout);
      stim_row_type row;
      row.req.req_type  = code;
      row.req.value_in  = word;
      row.typed         = typed;
      row.want.status    = st;
      row.want.value_out = vout;
      row.want.last      = 1'b1;
      directed_rows.push_back(row);
   endfunction

   // entered just after a falling edge, returns at the falling edge after the transfer
   task automatic send_request(input lss_req_type r, input bit typed, input lss_rsp_type want);
      while (!calm && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      cur_typed <= typed;
      cur_want  <= want;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   // result side: random stalls, a calm stretch and one long hold-off
   initial begin
      holds_served = 0;
      forever begin
         @(negedge clock);
         if (hold_asks > holds_served) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(99) < 24);
      end
   end

   // compare first, then predict, so a stray result never matches a fresh expectation
   always @(posedge clock) begin
      lss_rsp_type want;
      int          n_before;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_done++;
            status_seen[rsp_data.status]++;
            if (pending_results_q.size() == 0) begin
               $error("result with nothing expected: status %0d value_out %h last %0d",
                      rsp_data.status, rsp_data.value_out, rsp_data.last);
               mismatches++;
            end else begin
               want = pending_results_q.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.value_out !== want.value_out) begin
                  $error("value_out: expected %h, got %h", want.value_out, rsp_data.value_out);
                  mismatches++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_data.last);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            requests_done++;
            n_before = pending_results_q.size();
            predict_stack_op(req_data);
            if (cur_typed) begin
               // table rows with a typed answer replace the predicted one
               while (pending_results_q.size() > n_before) void'(pending_results_q.pop_back());
               pending_results_q.push_back(cur_want);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_results_q.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      lss_req_type  r;
      lss_rsp_type  none;
      stim_row_type row;
      traffic_mix_type mix;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      cur_typed    = 1'b0;
      cur_want     = '0;
      calm         = 1'b0;
      hold_asks    = 0;
      shadow_count = 0;
      peak_depth   = 0;
      mismatches   = 0;
      requests_done = 0;
      results_done  = 0;
      quiet_cycles  = 0;
      none         = '0;
      foreach (status_seen[i]) status_seen[i] = 0;

      // empty stack after reset, unused codes, extreme words, then unwind
      add_row(REQ_POP,    32'h0,         1, ST_EMPTY, 32'h0);
      add_row(REQ_PEEK,   32'h0,         1, ST_EMPTY, 32'h0);
      add_row(REQ_SEARCH, 32'h0,         1, ST_EMPTY, 32'h0);
      add_row(REQ_DUMP,   32'hffff_ffff, 1, ST_EMPTY, 32'h0);
      add_row(3'd5,       32'hdead_beef, 0, ST_OK,    32'h0);
      add_row(3'd7,       32'hffff_ffff, 0, ST_OK,    32'h0);
      add_row(REQ_PUSH,   32'h7fff_ffff, 1, ST_OK,    32'h0);
      add_row(REQ_PUSH,   32'h8000_0000, 1, ST_OK,    32'h0);
      add_row(REQ_PUSH,   32'h0000_0000, 1, ST_OK,    32'h0);
      add_row(REQ_PUSH,   32'hffff_ffff, 1, ST_OK,    32'h0);
      add_row(REQ_PEEK,   32'h1234_5678, 1, ST_OK,    32'hffff_ffff);
      add_row(REQ_SEARCH, 32'h8000_0000, 0, ST_OK,    32'h0);
      add_row(REQ_SEARCH, 32'h1234_5678, 0, ST_OK,    32'h0);
      add_row(REQ_SEARCH, 32'h7fff_ffff, 0, ST_OK,    32'h0);
      add_row(REQ_DUMP,   32'h0,         0, ST_OK,    32'h0);
      add_row(REQ_POP,    32'h0,         1, ST_OK,    32'hffff_ffff);
      add_row(REQ_POP,    32'h0,         1, ST_OK,    32'h0000_0000);
      add_row(3'd6,       32'h5555_5555, 0, ST_OK,    32'h0);
      add_row(REQ_POP,    32'h0,         1, ST_OK,    32'h8000_0000);
      add_row(REQ_PUSH,   32'h0000_0001, 1, ST_OK,    32'h0);
      add_row(REQ_DUMP,   32'h0,         0, ST_OK,    32'h0);
      add_row(REQ_POP,    32'h0,         1, ST_OK,    32'h0000_0001);
      add_row(REQ_POP,    32'h0,         1, ST_OK,    32'h7fff_ffff);
      add_row(REQ_POP,    32'h0,         1, ST_EMPTY, 32'h0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_request(row.req, row.typed, row.want);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i < 80) mix = MIX_FILL;
         else if (i < 140) mix = MIX_BALANCED;
         else if (i < 220) mix = MIX_DRAIN;
         else if (i < 290) mix = MIX_FILL;
         else if (i < 330) mix = MIX_BALANCED;
         else mix = MIX_DRAIN;
         calm = (i >= 220 && i < 280);
         // long result hold-off while the stack is deep, so the block backs up
         if (i == 140) hold_asks++;
         if ($urandom_range(99) < 4) begin
            r.req_type = 3'($urandom_range(7, 5));
            r.value_in = $urandom;
            send_request(r, 1'b0, none);
         end
         send_request(pick_request(mix), 1'b0, none);
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      while (pending_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests and %0d results, peak depth %0d of %0d", requests_done,
               results_done, peak_depth, LSS_DEPTH);
      $display("results by status: ok %0d, full %0d, empty %0d, not found %0d",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
               status_seen[ST_NOTFOUND]);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
